// ===== src/fps_pkg.sv =====
`timescale 1ns / 1ps

package fps_pkg;

  // Field widths of the register file and the streams
  localparam int TIME_W     = 32;
  localparam int PATTERN_W  = 64;
  localparam int LENGTH_W   = 7;
  localparam int TICKS_W    = 16;
  localparam int CYCLE_W    = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int OUT_DATA_W = 8;

  // Default sizing
  localparam int DEF_MAX_SLOTS = 64;
  localparam int DEF_TIME_BITS = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE    = 3'd5;

  // Reset values of the register file
  localparam logic [PATTERN_W-1:0] RST_PATTERN_BITS   = 64'd1;
  localparam logic [LENGTH_W-1:0]  RST_PATTERN_LENGTH = 7'd2;
  localparam logic [TICKS_W-1:0]   RST_ON_TICKS       = 16'd1;
  localparam logic [TICKS_W-1:0]   RST_OFF_TICKS      = 16'd1;
  localparam logic [TIME_W-1:0]    RST_START_TIME     = 32'd0;
  localparam logic                 RST_REPEAT_MODE    = 1'b1;
  localparam logic [CYCLE_W-1:0]   RST_CYCLE_LENGTH   = 23'd2;

  // Repeat mode codes
  localparam logic MODE_SINGLE = 1'b0;
  localparam logic MODE_REPEAT = 1'b1;

  // Register file as seen by the sequencer
  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_bits;
    logic [LENGTH_W-1:0]  pattern_length;
    logic [TICKS_W-1:0]   on_ticks;
    logic [TICKS_W-1:0]   off_ticks;
    logic [TIME_W-1:0]    start_time;
    logic                 repeat_mode;
  } cfg_t;

endpackage

// ===== src/flash_pattern_sampler_top.sv =====
`timescale 1ns / 1ps
// Flash pattern sampler: tells whether a blinking light is lit at a given tick.
// Input stream s_axis carries one query time per transaction; output stream
// m_axis returns one lit flag per query, in order.
// Configuration goes through cfg_we / cfg_index / cfg_data; the user must keep the
// block idle (not enforced); a write takes effect at the edge where cfg_we is high.
// A write to the pattern, length, on or off register starts a period recompute
// through the slot adder, with s_axis_tready low meanwhile.
// A query goes from the accepting edge through a setup step, then in repeat mode
// through the bit-serial modulo unit, then through a slot walk up to the slot
// that holds the time, and then into the output register; when setup finds the
// answer off at once, it goes straight to the output register. One query is in
// work at a time; the sequencer returns to idle as the result moves to the
// output register, and takes the next query from there.
// The result sits in an output register; the next query is taken while it waits.
// When the receiver stalls, m_axis_tvalid and m_axis_tdata hold, and a second
// finished result waits inside the sequencer until the register frees.
// Reset restores the default configuration (period two ticks), empties the
// output register and leaves the block ready at once.
module flash_pattern_sampler_top #(
  parameter int MAX_SLOTS = fps_pkg::DEF_MAX_SLOTS,
  parameter int TIME_BITS = fps_pkg::DEF_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fps_pkg::TIME_W-1:0]    s_axis_tdata,   // [31:0] query_time
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fps_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [0] lit, [7:1] zero
  input  logic                          cfg_we,
  input  logic [fps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fps_pkg::*;

  cfg_t cfg;
  logic recalc_req;
  logic res_valid;
  logic res_ready;
  logic res_lit;
  logic out_lit;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bits   <= RST_PATTERN_BITS;
      cfg.pattern_length <= RST_PATTERN_LENGTH;
      cfg.on_ticks       <= RST_ON_TICKS;
      cfg.off_ticks      <= RST_OFF_TICKS;
      cfg.start_time     <= RST_START_TIME;
      cfg.repeat_mode    <= RST_REPEAT_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BITS:   cfg.pattern_bits   <= cfg_data[PATTERN_W-1:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[LENGTH_W-1:0];
        REG_ON_TICKS:       cfg.on_ticks       <= cfg_data[TICKS_W-1:0];
        REG_OFF_TICKS:      cfg.off_ticks      <= cfg_data[TICKS_W-1:0];
        REG_START_TIME:     cfg.start_time     <= cfg_data[TIME_W-1:0];
        REG_REPEAT_MODE:    cfg.repeat_mode    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Period depends on the first four registers
  assign recalc_req = cfg_we && (cfg_index == REG_PATTERN_BITS ||
                                 cfg_index == REG_PATTERN_LENGTH ||
                                 cfg_index == REG_ON_TICKS ||
                                 cfg_index == REG_OFF_TICKS);

  fps_core #(
    .MAX_SLOTS (MAX_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .recalc_req (recalc_req),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_time    (s_axis_tdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_lit    (res_lit)
  );

  // Output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
      out_lit       <= res_lit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, out_lit};

endmodule

// ===== src/fps_core.sv =====
`timescale 1ns / 1ps

module fps_core #(
  parameter int MAX_SLOTS = fps_pkg::DEF_MAX_SLOTS,
  parameter int TIME_BITS = fps_pkg::DEF_TIME_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fps_pkg::cfg_t             cfg,
  input  logic                      recalc_req,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [fps_pkg::TIME_W-1:0] in_time,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic                      res_lit
);
  import fps_pkg::*;

  localparam int QW    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int CW    = (QW > CYCLE_W) ? QW : CYCLE_W;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int BIT_W = $clog2(QW + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RECALC = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_MOD    = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]         state;
  logic               pending;
  logic [CYCLE_W-1:0] cycle_len;
  logic [CYCLE_W-1:0] acc;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [QW-1:0]      mag;
  logic [QW-1:0]      div_sh;
  logic [CYCLE_W-1:0] rem;
  logic [BIT_W-1:0]   bitcnt;
  logic [CYCLE_W-1:0] tpos;
  logic               lit;

  // Slots in use, saturated to the slot count
  logic [CNT_W-1:0] slots_n;
  always_comb begin
    if (cfg.pattern_length > LENGTH_W'(MAX_SLOTS)) begin
      slots_n = CNT_W'(MAX_SLOTS);
    end else begin
      slots_n = CNT_W'(cfg.pattern_length);
    end
  end

  // Shared slot adder: acc plus duration of slot cnt
  logic               slot_on;
  logic [TICKS_W-1:0] slot_dur;
  logic [CYCLE_W-1:0] acc_sum;
  logic [IDX_W-1:0]   slot_idx;
  assign slot_idx = cnt[IDX_W-1:0];
  assign slot_on  = cfg.pattern_bits[slot_idx];
  assign slot_dur = slot_on ? cfg.on_ticks : cfg.off_ticks;
  assign acc_sum  = acc + CYCLE_W'(slot_dur);

  // Relative time, sign and magnitude
  logic [QW-1:0] q_m;
  logic [QW-1:0] s_m;
  logic [QW:0]   diff;
  assign q_m  = in_time[QW-1:0];
  assign s_m  = cfg.start_time[QW-1:0];
  assign diff = {1'b0, q_m} - {1'b0, s_m};

  // Restoring modulo step, one dividend bit per cycle
  logic [CYCLE_W:0]   trial;
  logic [CYCLE_W:0]   per_ext;
  logic [CYCLE_W-1:0] rem_step;
  assign trial   = {rem, div_sh[QW-1]};
  assign per_ext = {1'b0, cycle_len};
  always_comb begin
    if (trial >= per_ext) begin
      rem_step = CYCLE_W'(trial - per_ext);
    end else begin
      rem_step = trial[CYCLE_W-1:0];
    end
  end

  logic [CW-1:0] mag_ext;
  assign mag_ext = CW'(mag);

  assign in_ready  = (state == ST_IDLE) && !pending;
  assign res_valid = (state == ST_DONE);
  assign res_lit   = lit;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      cycle_len <= RST_CYCLE_LENGTH;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pending) begin
            pending <= 1'b0;
            acc     <= '0;
            cnt     <= '0;
            state   <= ST_RECALC;
          end else if (in_valid) begin
            neg   <= diff[QW];
            mag   <= diff[QW] ? (QW'(0) - diff[QW-1:0]) : diff[QW-1:0];
            state <= ST_PREP;
          end
        end
        ST_RECALC: begin
          if (pending) begin
            // a later write restarts the sum
            pending <= 1'b0;
            acc     <= '0;
            cnt     <= '0;
          end else if (cnt == slots_n) begin
            cycle_len <= acc;
            state     <= ST_IDLE;
          end else begin
            acc <= acc_sum;
            cnt <= cnt + 1'b1;
          end
        end
        ST_PREP: begin
          acc <= '0;
          cnt <= '0;
          if (slots_n == '0 || cycle_len == '0) begin
            lit   <= 1'b0;
            state <= ST_DONE;
          end else if (cfg.repeat_mode == MODE_REPEAT) begin
            div_sh <= neg ? (mag - 1'b1) : mag;
            rem    <= '0;
            bitcnt <= BIT_W'(QW);
            state  <= ST_MOD;
          end else if (neg || mag_ext >= CW'(cycle_len)) begin
            lit   <= 1'b0;
            state <= ST_DONE;
          end else begin
            tpos  <= mag_ext[CYCLE_W-1:0];
            state <= ST_WALK;
          end
        end
        ST_MOD: begin
          rem    <= rem_step;
          div_sh <= div_sh << 1;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == BIT_W'(1)) begin
            // floored wrap for times before start
            tpos  <= neg ? (cycle_len - 1'b1 - rem_step) : rem_step;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cnt == slots_n) begin
            lit   <= 1'b0;
            state <= ST_DONE;
          end else if (tpos < acc_sum) begin
            lit   <= slot_on;
            state <= ST_DONE;
          end else begin
            acc <= acc_sum;
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (recalc_req) begin
        pending <= 1'b1;
      end
    end
  end

endmodule

// ===== src/fps_checker.sv =====
`timescale 1ns / 1ps

module fps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [fps_pkg::TIME_W-1:0]     s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           cfg_we,
  input logic [fps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [fps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fps_pkg::*;

  // Output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One query in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("query taken while busy");

  // Period recompute blocks queries
  a_recalc_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_PATTERN_BITS || cfg_index == REG_PATTERN_LENGTH ||
               cfg_index == REG_ON_TICKS || cfg_index == REG_OFF_TICKS)
    |=> !s_axis_tready)
    else $error("query ready during period recompute");

  // Padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
    else $error("result padding not zero");

endmodule

bind flash_pattern_sampler_top fps_checker u_fps_checker (.*);
